// ===== rtl/core/ptw_pkg.sv =====
// Shared types, widths and codes for the four-level page table walker.
// No dependencies; ptw_ctrl, ptw_datapath and the top level import this package.
`timescale 1ns / 1ps

package ptw_pkg;

  localparam int MEM_WORDS_DEFAULT = 4096;

  localparam int ENTRY_W      = 64;
  localparam int LA_W         = 48;
  localparam int FRAME_W      = 36;
  localparam int IDX_W        = 9;
  localparam int WORD_INDEX_W = 12;
  localparam int LEVELS_W     = 3;
  localparam int LEVEL_W      = 2;
  localparam int WORD_ADDR_W  = FRAME_W + IDX_W;

  localparam int FRAME_LSB      = 12;
  localparam int FRAME_MSB      = 47;
  localparam int LARGE_PAGE_BIT = 7;

  localparam logic OP_WALK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_TOP  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PTR  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_DIR  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_LEAF = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic write;  // store one table word
    logic load;   // begin a walk, issue the top-level read
    logic step;   // consume the entry returned by the memory
  } ptw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic first_ok;  // top-level entry address lies inside memory
    logic walk_end;  // entry on hand finishes the walk
  } ptw_stat_t;

  // Table index for one level, taken from linear address bits 47:12.
  function automatic logic [IDX_W-1:0] level_index(input logic [FRAME_W-1:0] vpn,
                                                   input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_TOP:  idx = vpn[35:27];
      LVL_PTR:  idx = vpn[26:18];
      LVL_DIR:  idx = vpn[17:9];
      LVL_LEAF: idx = vpn[8:0];
      default:  idx = vpn[8:0];
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/core/ptw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ptw_ctrl.sv =====
// Walk controller: sequences write and walk items, drives busy and the result strobe.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               operation,
  input  ptw_pkg::ptw_stat_t stat,
  output ptw_pkg::ptw_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import ptw_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_WALK: cmd.step = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign busy = (state == ST_WALK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            // Root table outside memory: report at once.
            if (stat.first_ok) begin
              state <= ST_WALK;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (stat.walk_end) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ptw_datapath.sv =====
// Walk datapath: table memory, address forming and range check, entry capture.
// Depends on ptw_pkg and ptw_ram.
`timescale 1ns / 1ps

module ptw_datapath #(
  parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ptw_pkg::ptw_cmd_t                cmd,
  output ptw_pkg::ptw_stat_t               stat,
  input  logic                             cfg_write,
  input  logic [ptw_pkg::FRAME_W-1:0]      cfg_data,
  input  logic [ptw_pkg::LA_W-1:0]         linear_address,
  input  logic [ptw_pkg::WORD_INDEX_W-1:0] word_index,
  input  logic [ptw_pkg::ENTRY_W-1:0]      word_value,
  output logic [ptw_pkg::ENTRY_W-1:0]      top_entry,
  output logic [ptw_pkg::ENTRY_W-1:0]      pointer_entry,
  output logic [ptw_pkg::ENTRY_W-1:0]      directory_entry,
  output logic [ptw_pkg::ENTRY_W-1:0]      leaf_entry,
  output logic [ptw_pkg::LEVELS_W-1:0]     levels_read,
  output logic                             status
);
  import ptw_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [WORD_ADDR_W-1:0] MEM_LIMIT = WORD_ADDR_W'(MEM_WORDS);

  logic [FRAME_W-1:0]     root_table_frame;
  logic [FRAME_W-1:0]     vpn;
  logic [LEVEL_W-1:0]     lvl;
  logic [ENTRY_W-1:0]     rdata;
  logic [FRAME_W-1:0]     frame_sel;
  logic [IDX_W-1:0]       idx_sel;
  logic [WORD_ADDR_W-1:0] walk_addr;
  logic [WORD_ADDR_W-1:0] write_addr;
  logic                   addr_ok;
  logic                   stop_here;
  logic                   ram_re;
  logic                   ram_we;

  // Next table address: root frame on load, else frame of the returned entry.
  always_comb begin
    if (cmd.load) begin
      frame_sel = root_table_frame;
      idx_sel   = level_index(linear_address[FRAME_MSB:FRAME_LSB], LVL_TOP);
    end else begin
      frame_sel = rdata[FRAME_MSB:FRAME_LSB];
      idx_sel   = level_index(vpn, lvl + 2'd1);
    end
  end

  assign walk_addr = {frame_sel, idx_sel};
  assign addr_ok   = (walk_addr < MEM_LIMIT);
  assign stop_here = (lvl == LVL_LEAF) ||
                     (((lvl == LVL_PTR) || (lvl == LVL_DIR)) && rdata[LARGE_PAGE_BIT]);

  assign stat.first_ok = addr_ok;
  assign stat.walk_end = stop_here || !addr_ok;

  assign ram_re     = (cmd.load && addr_ok) || (cmd.step && !stop_here && addr_ok);
  assign write_addr = WORD_ADDR_W'(word_index);
  assign ram_we     = cmd.write && (write_addr < MEM_LIMIT);

  ptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_WORDS),
    .AW    (AW)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_addr[AW-1:0]),
    .wdata (word_value),
    .re    (ram_re),
    .raddr (walk_addr[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_frame <= '0;
      lvl              <= LVL_TOP;
    end else begin
      if (cfg_write) begin
        root_table_frame <= cfg_data;
      end
      if (cmd.load) begin
        lvl <= LVL_TOP;
      end else if (cmd.step) begin
        lvl <= lvl + 2'd1;
      end
    end
  end

  // Entry capture and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vpn             <= linear_address[FRAME_MSB:FRAME_LSB];
      top_entry       <= '0;
      pointer_entry   <= '0;
      directory_entry <= '0;
      leaf_entry      <= '0;
      levels_read     <= '0;
      status          <= !addr_ok;
    end else if (cmd.step) begin
      case (lvl)
        LVL_TOP:  top_entry       <= rdata;
        LVL_PTR:  pointer_entry   <= rdata;
        LVL_DIR:  directory_entry <= rdata;
        LVL_LEAF: leaf_entry      <= rdata;
        default:  leaf_entry      <= rdata;
      endcase
      levels_read <= {1'b0, lvl} + 3'd1;
      if (!stop_here && !addr_ok) begin
        status <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/four_level_page_table_walker.sv =====
// Top level of the four-level page table walker: controller plus datapath.
// Depends on ptw_pkg, ptw_ctrl, ptw_datapath (and ptw_ram below it).
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// -------   ---------------------   ---------------------------------------------
// input     start & !busy           operation, linear_address, word_index,
//                                   word_value
// result    done (one cycle)        top_entry, pointer_entry, directory_entry,
//                                   leaf_entry, levels_read, status
// config    cfg_write               cfg_data (root_table_frame)
//
// A write item is stored on acceptance and leaves busy low. A walk item holds
// busy while one to four table levels are read, bounded by the registered
// read of the table RAM: each returned entry forms the next read address in
// the same cycle. done pulses the cycle after the last level; a root table
// outside memory gives done the cycle after acceptance with busy never set.
// Synchronous reset clears the controller and the root frame; the table RAM
// is not cleared. The receiver cannot stall: done marks each result for one cycle.

module four_level_page_table_walker #(
  parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation,
  input  logic [ptw_pkg::LA_W-1:0]         linear_address,
  input  logic [ptw_pkg::WORD_INDEX_W-1:0] word_index,
  input  logic [ptw_pkg::ENTRY_W-1:0]      word_value,
  input  logic                             cfg_write,
  input  logic [ptw_pkg::FRAME_W-1:0]      cfg_data,
  output logic                             done,
  output logic [ptw_pkg::ENTRY_W-1:0]      top_entry,
  output logic [ptw_pkg::ENTRY_W-1:0]      pointer_entry,
  output logic [ptw_pkg::ENTRY_W-1:0]      directory_entry,
  output logic [ptw_pkg::ENTRY_W-1:0]      leaf_entry,
  output logic [ptw_pkg::LEVELS_W-1:0]     levels_read,
  output logic                             status
);
  import ptw_pkg::*;

  ptw_cmd_t  cmd;
  ptw_stat_t stat;

  // Sequence items: write on acceptance, walk one level per cycle.
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // Hold the table memory, root frame and the entries read so far.
  ptw_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .linear_address  (linear_address),
    .word_index      (word_index),
    .word_value      (word_value),
    .top_entry       (top_entry),
    .pointer_entry   (pointer_entry),
    .directory_entry (directory_entry),
    .leaf_entry      (leaf_entry),
    .levels_read     (levels_read),
    .status          (status)
  );

endmodule
